// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while rst is high
`define ACC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while rst is high
`define ACC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define ACC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/acc_alu_pkg.sv =====
// ----------------------------------------------------------------------------
// acc_alu_pkg
// field widths, codes, micro-op set and microcode rom of the accumulator alu
// ----------------------------------------------------------------------------
package acc_alu_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int KIND_W         = 3;
  localparam int OPERAND_W      = 32;
  localparam int VALUE_W        = 32;
  localparam int ERROR_W        = 2;
  localparam int UADDR_W        = 5;

  // operation kinds
  localparam logic [KIND_W-1:0] KIND_LOAD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUB  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MUL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POW  = 3'd5;

  // error codes
  localparam logic [ERROR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERROR_W-1:0] ERR_DIV_ZERO = 2'd1;
  localparam logic [ERROR_W-1:0] ERR_NEG_EXP  = 2'd2;

  // datapath micro-ops
  typedef enum logic [4:0] {
    OP_NOP, OP_LATCH, OP_LOAD, OP_ADD, OP_SUB,
    OP_MUL_INIT, OP_MUL_STEP, OP_MUL_DONE,
    OP_DIV_INIT, OP_DIV_STEP, OP_DIV_DONE,
    OP_POW_INIT, OP_MR_INIT, OP_RES_WB, OP_SQ_INIT, OP_SQ_WB, OP_POW_DONE,
    OP_ERR_DZ, OP_ERR_NE, OP_EMIT
  } op_e;

  // sequencer jump conditions
  typedef enum logic [3:0] {
    C_NEXT, C_ALWAYS, C_NO_REQ, C_DISPATCH, C_CNT_MORE,
    C_B_ZERO, C_B_NEG, C_E_ZERO, C_E_EVEN, C_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e                op;
    cond_e              cond;
    logic [UADDR_W-1:0] target;
  } uword_t;

  // control from sequencer to datapath
  typedef struct packed {
    op_e  op;
    logic ready;
    logic take;
    logic emit;
  } ctrl_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              b_zero;
    logic              b_neg;
    logic              e_zero;
    logic              e_odd;
    logic              cnt_last;
    logic              out_free;
  } stat_t;

  // microcode addresses
  localparam logic [UADDR_W-1:0] A_IDLE     = 5'd0;
  localparam logic [UADDR_W-1:0] A_DISPATCH = 5'd1;
  localparam logic [UADDR_W-1:0] A_LOAD     = 5'd2;
  localparam logic [UADDR_W-1:0] A_ADD      = 5'd3;
  localparam logic [UADDR_W-1:0] A_SUB      = 5'd4;
  localparam logic [UADDR_W-1:0] A_MUL      = 5'd5;
  localparam logic [UADDR_W-1:0] A_MUL_LOOP = 5'd6;
  localparam logic [UADDR_W-1:0] A_MUL_DONE = 5'd7;
  localparam logic [UADDR_W-1:0] A_DIV      = 5'd8;
  localparam logic [UADDR_W-1:0] A_DIV_INIT = 5'd9;
  localparam logic [UADDR_W-1:0] A_DIV_LOOP = 5'd10;
  localparam logic [UADDR_W-1:0] A_DIV_DONE = 5'd11;
  localparam logic [UADDR_W-1:0] A_POW      = 5'd12;
  localparam logic [UADDR_W-1:0] A_POW_LOOP = 5'd13;
  localparam logic [UADDR_W-1:0] A_POW_BIT  = 5'd14;
  localparam logic [UADDR_W-1:0] A_MR_INIT  = 5'd15;
  localparam logic [UADDR_W-1:0] A_MR_LOOP  = 5'd16;
  localparam logic [UADDR_W-1:0] A_RES_WB   = 5'd17;
  localparam logic [UADDR_W-1:0] A_SQ_INIT  = 5'd18;
  localparam logic [UADDR_W-1:0] A_SQ_LOOP  = 5'd19;
  localparam logic [UADDR_W-1:0] A_SQ_WB    = 5'd20;
  localparam logic [UADDR_W-1:0] A_POW_DONE = 5'd21;
  localparam logic [UADDR_W-1:0] A_ERR_DZ   = 5'd22;
  localparam logic [UADDR_W-1:0] A_ERR_NE   = 5'd23;
  localparam logic [UADDR_W-1:0] A_EMIT     = 5'd24;

  function automatic uword_t urom(input logic [UADDR_W-1:0] addr);
    uword_t w;
    case (addr)
      A_IDLE:     w = '{OP_LATCH,    C_NO_REQ,   A_IDLE};
      A_DISPATCH: w = '{OP_NOP,      C_DISPATCH, A_EMIT};
      A_LOAD:     w = '{OP_LOAD,     C_ALWAYS,   A_EMIT};
      A_ADD:      w = '{OP_ADD,      C_ALWAYS,   A_EMIT};
      A_SUB:      w = '{OP_SUB,      C_ALWAYS,   A_EMIT};
      A_MUL:      w = '{OP_MUL_INIT, C_NEXT,     A_MUL_LOOP};
      A_MUL_LOOP: w = '{OP_MUL_STEP, C_CNT_MORE, A_MUL_LOOP};
      A_MUL_DONE: w = '{OP_MUL_DONE, C_ALWAYS,   A_EMIT};
      A_DIV:      w = '{OP_NOP,      C_B_ZERO,   A_ERR_DZ};
      A_DIV_INIT: w = '{OP_DIV_INIT, C_NEXT,     A_DIV_LOOP};
      A_DIV_LOOP: w = '{OP_DIV_STEP, C_CNT_MORE, A_DIV_LOOP};
      A_DIV_DONE: w = '{OP_DIV_DONE, C_ALWAYS,   A_EMIT};
      A_POW:      w = '{OP_POW_INIT, C_B_NEG,    A_ERR_NE};
      A_POW_LOOP: w = '{OP_NOP,      C_E_ZERO,   A_POW_DONE};
      A_POW_BIT:  w = '{OP_NOP,      C_E_EVEN,   A_SQ_INIT};
      A_MR_INIT:  w = '{OP_MR_INIT,  C_NEXT,     A_MR_LOOP};
      A_MR_LOOP:  w = '{OP_MUL_STEP, C_CNT_MORE, A_MR_LOOP};
      A_RES_WB:   w = '{OP_RES_WB,   C_NEXT,     A_SQ_INIT};
      A_SQ_INIT:  w = '{OP_SQ_INIT,  C_NEXT,     A_SQ_LOOP};
      A_SQ_LOOP:  w = '{OP_MUL_STEP, C_CNT_MORE, A_SQ_LOOP};
      A_SQ_WB:    w = '{OP_SQ_WB,    C_ALWAYS,   A_POW_LOOP};
      A_POW_DONE: w = '{OP_POW_DONE, C_ALWAYS,   A_EMIT};
      A_ERR_DZ:   w = '{OP_ERR_DZ,   C_ALWAYS,   A_EMIT};
      A_ERR_NE:   w = '{OP_ERR_NE,   C_ALWAYS,   A_EMIT};
      A_EMIT:     w = '{OP_EMIT,     C_OUT_FREE, A_IDLE};
      default:    w = '{OP_NOP,      C_ALWAYS,   A_IDLE};
    endcase
    return w;
  endfunction

  // entry point of each operation kind
  function automatic logic [UADDR_W-1:0] dispatch(input logic [KIND_W-1:0] kind);
    logic [UADDR_W-1:0] a;
    case (kind)
      KIND_LOAD: a = A_LOAD;
      KIND_ADD:  a = A_ADD;
      KIND_SUB:  a = A_SUB;
      KIND_MUL:  a = A_MUL;
      KIND_DIV:  a = A_DIV;
      KIND_POW:  a = A_POW;
      default:   a = A_EMIT;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/acc_alu_req_if.sv =====
// ----------------------------------------------------------------------------
// acc_alu_req_if
// request channel: operation kind and signed operand
// ----------------------------------------------------------------------------
interface acc_alu_req_if
  import acc_alu_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic        [KIND_W-1:0]    kind;
  logic signed [OPERAND_W-1:0] operand;

  modport source (output valid, kind, operand, input ready);
  modport sink   (input valid, kind, operand, output ready);
endinterface

// ===== sv/acc_alu_res_if.sv =====
// ----------------------------------------------------------------------------
// acc_alu_res_if
// result channel: accumulator value and error code
// ----------------------------------------------------------------------------
interface acc_alu_res_if
  import acc_alu_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic        [ERROR_W-1:0] error;

  modport source (output valid, value, error, input ready);
  modport sink   (input valid, value, error, output ready);
endinterface

// ===== sv/acc_alu_useq.sv =====
// ----------------------------------------------------------------------------
// acc_alu_useq
// microcode sequencer: step counter, rom lookup and conditional jumps
// ----------------------------------------------------------------------------
module acc_alu_useq
  import acc_alu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [UADDR_W-1:0] upc;
  logic [UADDR_W-1:0] upc_next;
  logic [UADDR_W-1:0] upc_inc;
  uword_t             uw;

  assign uw      = urom(upc);
  assign upc_inc = upc + UADDR_W'(1);

  always_comb begin
    ctrl.op    = uw.op;
    ctrl.ready = (uw.op == OP_LATCH);
    ctrl.take  = (uw.op == OP_LATCH) && in_valid;
    ctrl.emit  = (uw.op == OP_EMIT) && stat.out_free;
  end

  always_comb begin
    case (uw.cond)
      C_NEXT:     upc_next = upc_inc;
      C_ALWAYS:   upc_next = uw.target;
      C_NO_REQ:   upc_next = in_valid ? upc_inc : uw.target;
      C_DISPATCH: upc_next = dispatch(stat.kind);
      C_CNT_MORE: upc_next = stat.cnt_last ? upc_inc : uw.target;
      C_B_ZERO:   upc_next = stat.b_zero ? uw.target : upc_inc;
      C_B_NEG:    upc_next = stat.b_neg ? uw.target : upc_inc;
      C_E_ZERO:   upc_next = stat.e_zero ? uw.target : upc_inc;
      C_E_EVEN:   upc_next = stat.e_odd ? upc_inc : uw.target;
      C_OUT_FREE: upc_next = stat.out_free ? uw.target : upc;
      default:    upc_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= A_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== sv/acc_alu_dpath.sv =====
// ----------------------------------------------------------------------------
// acc_alu_dpath
// accumulator datapath with bit-serial multiplier and restoring divider
// ----------------------------------------------------------------------------
module acc_alu_dpath
  import acc_alu_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ctrl_t                       ctrl,
  input  logic        [KIND_W-1:0]    in_kind,
  input  logic signed [OPERAND_W-1:0] in_operand,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic        [VALUE_W-1:0]   out_value,
  output logic        [ERROR_W-1:0]   out_error,
  output stat_t                       stat
);

  localparam int W     = DATA_WIDTH;
  localparam int CNT_W = $clog2(DATA_WIDTH);

  logic [KIND_W-1:0]  kind_r;
  logic [W-1:0]       b;
  logic [W-1:0]       acc;
  logic [ERROR_W-1:0] err;
  logic [W-1:0]       x;
  logic [W-1:0]       y;
  logic [W-1:0]       p;
  logic [W-1:0]       rem;
  logic [W-1:0]       quo;
  logic [W-1:0]       den;
  logic               div_neg;
  logic [W-1:0]       res;
  logic [W-1:0]       sq;
  logic [W-1:0]       e;
  logic [CNT_W-1:0]   cnt;

  logic [W-1:0]       b_in;
  logic [W-1:0]       acc_mag;
  logic [W-1:0]       b_mag;
  logic [W:0]         rem_sh;
  logic [W:0]         rem_diff;
  logic               rem_ge;

  // sign-extend or truncate the operand to the accumulator width
  assign b_in    = W'(in_operand);
  assign acc_mag = acc[W-1] ? (W'(0) - acc) : acc;
  assign b_mag   = b[W-1] ? (W'(0) - b) : b;

  // one restoring division step
  assign rem_sh   = {rem, quo[W-1]};
  assign rem_diff = rem_sh - {1'b0, den};
  assign rem_ge   = (rem_sh >= {1'b0, den});

  always_comb begin
    stat.kind     = kind_r;
    stat.b_zero   = (b == '0);
    stat.b_neg    = b[W-1];
    stat.e_zero   = (e == '0);
    stat.e_odd    = e[0];
    stat.cnt_last = (cnt == CNT_W'(W - 1));
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.take) begin
        kind_r <= in_kind;
        b      <= b_in;
        err    <= ERR_NONE;
      end

      case (ctrl.op)
        OP_LOAD: acc <= b;
        OP_ADD:  acc <= acc + b;
        OP_SUB:  acc <= acc - b;
        OP_MUL_INIT: begin
          x   <= acc;
          y   <= b;
          p   <= '0;
          cnt <= '0;
        end
        OP_MUL_STEP: begin
          if (y[0]) begin
            p <= p + x;
          end
          x   <= x << 1;
          y   <= y >> 1;
          cnt <= cnt + CNT_W'(1);
        end
        OP_MUL_DONE: acc <= p;
        OP_DIV_INIT: begin
          rem     <= '0;
          quo     <= acc_mag;
          den     <= b_mag;
          div_neg <= acc[W-1] ^ b[W-1];
          cnt     <= '0;
        end
        OP_DIV_STEP: begin
          rem <= rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
          quo <= {quo[W-2:0], rem_ge};
          cnt <= cnt + CNT_W'(1);
        end
        OP_DIV_DONE: acc <= div_neg ? (W'(0) - quo) : quo;
        OP_POW_INIT: begin
          res <= W'(1);
          sq  <= acc;
          e   <= b;
        end
        OP_MR_INIT: begin
          x   <= res;
          y   <= sq;
          p   <= '0;
          cnt <= '0;
        end
        OP_RES_WB: res <= p;
        OP_SQ_INIT: begin
          x   <= sq;
          y   <= sq;
          p   <= '0;
          cnt <= '0;
        end
        OP_SQ_WB: begin
          sq <= p;
          e  <= e >> 1;
        end
        OP_POW_DONE: acc <= res;
        OP_ERR_DZ:   err <= ERR_DIV_ZERO;
        OP_ERR_NE:   err <= ERR_NEG_EXP;
        default: ;
      endcase

      // result register, zero-extended or truncated to the port width
      if (ctrl.emit) begin
        out_valid <= 1'b1;
        out_value <= VALUE_W'(acc);
        out_error <= err;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/accumulator_integer_alu.sv =====
// ----------------------------------------------------------------------------
// accumulator_integer_alu
// microcoded accumulator calculator: load, add, sub, mul, div and power
// ----------------------------------------------------------------------------
// latency of multiply, divide and power grows with W = DATA_WIDTH, since the
// shift-add multiplier and the restoring divider work bit-serially; power
// squares once per exponent bit and multiplies into the result on set bits
// one request in flight; a new request is taken while a result still waits
// reset (rst, synchronous): accumulator zero, sequencer idle, result empty
module accumulator_integer_alu
  import acc_alu_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst,
  acc_alu_req_if.sink  req,
  acc_alu_res_if.source res
);

  // control word fields and status flags between the two halves
  ctrl_t ctrl;
  stat_t stat;

  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  logic [ERROR_W-1:0] out_error;

  // sequencer: walks the microcode rom, one control word per cycle.
  // the idle word latches a request; dispatch jumps on the kind; loops for
  // multiply, divide and the square-and-multiply rounds count on the
  // datapath's bit counter; the emit word waits until the result register
  // can take a new value
  acc_alu_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // datapath: accumulator, latched operand, shared shift-add multiplier
  // (also used for the squaring and the result update of power), restoring
  // divider on magnitudes with a final sign fix, and the result register
  acc_alu_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .in_kind    (req.kind),
    .in_operand (req.operand),
    .out_ready  (res.ready),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .out_error  (out_error),
    .stat       (stat)
  );

  // ready only while the idle word is on; the result register parts the
  // two sides, so a waiting result never holds off the next request
  assign req.ready = ctrl.ready;
  assign res.valid = out_valid;
  assign res.value = out_value;
  assign res.error = out_error;

endmodule

// ===== sv/acc_alu_chk.sv =====
// ----------------------------------------------------------------------------
// acc_alu_chk
// port-level checks of the accumulator alu, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acc_alu_chk
  import acc_alu_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [VALUE_W-1:0] res_value,
  input logic [ERROR_W-1:0] res_error
);

  logic [1:0] pend;
  logic       req_fire;
  logic       res_fire;

  assign req_fire = req_valid && req_ready;
  assign res_fire = res_valid && res_ready;

  // requests taken whose results are not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
    end else begin
      pend <= pend + {1'b0, req_fire} - {1'b0, res_fire};
    end
  end

  `ACC_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_value) && $stable(res_error), "stalled result changed")
  `ACC_ASSERT_NXT(a_req_busy, req_fire, !req_ready, "request taken while one is at work")
  `ACC_ASSERT_IMP(a_res_pending, res_valid, pend != 2'd0, "result without a request")
  `ACC_ASSERT_IMP(a_pend_bound, 1'b1, pend != 2'd3, "more than two requests outstanding")
  `ACC_ASSERT_RST(a_rst_empty, rst, !res_valid, "result valid after reset")

endmodule

bind accumulator_integer_alu acc_alu_chk u_acc_alu_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_value (res.value),
  .res_error (res.error)
);

// ===== verif/acc_alu_checker.sv =====
// ----------------------------------------------------------------------------
// acc_alu_checker
// watches both channels of the accumulator alu, predicts each result from
// the accepted requests and compares value and error field by field
// ----------------------------------------------------------------------------
module acc_alu_checker
  import acc_alu_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  acc_alu_req_if req,
  acc_alu_res_if res,
  output int     fail_count,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [ERROR_W-1:0] error;
  } alu_result_t;

  logic [VALUE_W-1:0] acc_model;
  alu_result_t        expected_results[$];

  // applies one operation to the shadow accumulator, all arithmetic wraps
  function automatic alu_result_t step_accumulator(input logic [KIND_W-1:0] kind,
                                                   input logic [OPERAND_W-1:0] b);
    alu_result_t        r;
    logic [VALUE_W-1:0] mag_a;
    logic [VALUE_W-1:0] mag_b;
    logic [VALUE_W-1:0] quo;
    logic [VALUE_W-1:0] prod;
    logic [VALUE_W-1:0] sq;
    logic [VALUE_W-1:0] e;
    r.error = ERR_NONE;
    case (kind)
      KIND_LOAD: acc_model = b;
      KIND_ADD:  acc_model = acc_model + b;
      KIND_SUB:  acc_model = acc_model - b;
      KIND_MUL:  acc_model = acc_model * b;
      KIND_DIV: begin
        if (b == '0) begin
          r.error = ERR_DIV_ZERO;
        end else begin
          // truncate toward zero on magnitudes
          mag_a = acc_model[VALUE_W-1] ? -acc_model : acc_model;
          mag_b = b[OPERAND_W-1] ? -b : b;
          quo   = mag_a / mag_b;
          if (acc_model[VALUE_W-1] ^ b[OPERAND_W-1]) quo = -quo;
          acc_model = quo;
        end
      end
      KIND_POW: begin
        if (b[OPERAND_W-1]) begin
          r.error = ERR_NEG_EXP;
        end else begin
          prod = 1;
          sq   = acc_model;
          e    = b;
          while (e != '0) begin
            if (e[0]) prod = prod * sq;
            sq = sq * sq;
            e  = e >> 1;
          end
          acc_model = prod;
        end
      end
      default: ;
    endcase
    r.value = acc_model;
    return r;
  endfunction

  always @(posedge clk) begin
    alu_result_t want;
    if (rst) begin
      acc_model = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // result first: it belongs to an older request than one taken now
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: value %0d error %0d", res.value, res.error);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (res.value !== want.value) begin
            $error("value mismatch: expected %0d, actual %0d",
                   $signed(want.value), res.value);
            fail_count++;
          end
          if (res.error !== want.error) begin
            $error("error mismatch: expected %0d, actual %0d", want.error, res.error);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready)
        expected_results.push_back(step_accumulator(req.kind, req.operand));
    end
    pending = expected_results.size();
  end

endmodule

// ===== verif/tb_accumulator_integer_alu.sv =====
// ----------------------------------------------------------------------------
// tb_accumulator_integer_alu
// stimulus and verdict for the accumulator alu: a directed pass over the
// wrap, divide and power corner cases, then weighted random requests with
// bursty sending and a stalling receiver; checking lives in acc_alu_checker
// ----------------------------------------------------------------------------
module tb_accumulator_integer_alu
  import acc_alu_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_OPS   = 266;
  // room for the longest power request, every exponent bit set, plus a margin
  localparam int DRAIN_CYCLES = 2400;
  // every request at its slowest with full gaps and stalls, several times over
  localparam int CYCLE_LIMIT  = 3_000_000;

  // kinds that the block passes over untouched
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   burst_left  = 0;

  acc_alu_req_if req_ch ();
  acc_alu_res_if res_ch ();

  accumulator_integer_alu u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  acc_alu_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: runs of ready broken by stalls of random length, some runs
  // with no stall in front of them at all
  initial begin
    int run_len;
    int stall_len;
    res_ch.ready = 1'b0;
    forever begin
      run_len   = $urandom_range(1, 30);
      stall_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      repeat (stall_len) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
      end
      repeat (run_len) begin
        @(negedge clk);
        res_ch.ready <= 1'b1;
      end
    end
  end

  // one request, called at a falling edge; sender works in bursts, and a
  // gap only opens when a burst has run out, so valid stays high inside one
  task automatic issue_request(input logic [KIND_W-1:0] kind,
                               input logic [OPERAND_W-1:0] operand);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.valid   <= 1'b1;
    req_ch.kind    <= kind;
    req_ch.operand <= operand;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // holds the sender off until every outstanding result is back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int                   pick;
    int                   sub;
    int                   accepted_ops;
    bit                   mid_pause_done;
    logic [KIND_W-1:0]    kind;
    logic [OPERAND_W-1:0] operand;

    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.kind    = KIND_LOAD;
    req_ch.operand = '0;
    accepted_ops   = 0;
    mid_pause_done = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: wrap at both ends of the range
    issue_request(KIND_LOAD, 32'h7FFF_FFFF);
    issue_request(KIND_ADD,  32'd1);
    issue_request(KIND_SUB,  32'd1);
    issue_request(KIND_MUL,  32'h7FFF_FFFF);
    // most negative over minus one wraps with no error, then divide by zero
    issue_request(KIND_LOAD, 32'h8000_0000);
    issue_request(KIND_DIV,  32'hFFFF_FFFF);
    issue_request(KIND_DIV,  32'h0000_0000);
    issue_request(KIND_MUL,  32'hFFFF_FFFF);
    // truncation toward zero, negative over positive and negative over negative
    issue_request(KIND_LOAD, 32'hFFFF_FFF9);
    issue_request(KIND_DIV,  32'd2);
    issue_request(KIND_DIV,  32'hFFFF_FFFE);
    // zero to the power zero is one, and a negative exponent is refused
    issue_request(KIND_LOAD, 32'd0);
    issue_request(KIND_POW,  32'd0);
    issue_request(KIND_POW,  32'h8000_0000);
    // power overflow keeps the low bits
    issue_request(KIND_LOAD, 32'd3);
    issue_request(KIND_POW,  32'd40);
    issue_request(KIND_LOAD, 32'd2);
    issue_request(KIND_POW,  32'd31);
    issue_request(KIND_SUB,  32'h8000_0000);
    // largest exponent, every bit below the sign set
    issue_request(KIND_LOAD, 32'hFFFF_FFFF);
    issue_request(KIND_POW,  32'h7FFF_FFFF);
    // unused kinds leave the accumulator alone
    issue_request(KIND_UNUSED_LO, 32'h1234_5678);
    issue_request(KIND_UNUSED_HI, 32'hFFFF_FFFF);
    issue_request(KIND_ADD,  32'h8000_0000);

    drain_results();

    // random part, weighted so that divide and power see useful operands
    while (accepted_ops < RANDOM_OPS) begin
      pick    = $urandom_range(0, 99);
      sub     = $urandom_range(0, 19);
      operand = $urandom;
      if (pick < 12) begin
        kind = KIND_LOAD;
      end else if (pick < 18) begin
        kind    = KIND_LOAD;
        operand = $urandom_range(0, 20) - 10;
      end else if (pick < 33) begin
        kind = KIND_ADD;
      end else if (pick < 46) begin
        kind = KIND_SUB;
      end else if (pick < 58) begin
        kind = KIND_MUL;
        if (sub < 10) operand = $urandom_range(0, 64) - 32;
      end else if (pick < 74) begin
        kind = KIND_DIV;
        if (sub < 3)       operand = '0;
        else if (sub < 6)  operand = '1;
        else if (sub < 13) operand = $urandom_range(0, 200) - 100;
      end else if (pick < 94) begin
        kind = KIND_POW;
        // mostly short exponents; a few long ones and some negative
        if (sub < 14)      operand = $urandom_range(0, 12);
        else if (sub < 16) operand = $urandom_range(13, 64);
        else if (sub < 19) operand[OPERAND_W-1] = 1'b1;
        else               operand[OPERAND_W-1] = 1'b0;
      end else begin
        kind = (sub < 10) ? KIND_UNUSED_LO : KIND_UNUSED_HI;
      end

      accepted_ops++;
      issue_request(kind, operand);

      // one pause in the middle so the block empties out completely
      if (!mid_pause_done && accepted_ops >= RANDOM_OPS / 2) begin
        mid_pause_done = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (pending != 0) $error("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/acc_alu_pkg.sv
sv/acc_alu_req_if.sv
sv/acc_alu_res_if.sv
sv/acc_alu_useq.sv
sv/acc_alu_dpath.sv
sv/accumulator_integer_alu.sv
sv/acc_alu_chk.sv
verif/acc_alu_checker.sv
verif/tb_accumulator_integer_alu.sv
